// File: sv/sine_cosine_minimax_macros.svh
// ----------------------------------------------------------------------------
// sine_cosine_minimax_macros
// assertion macros used by the checker file of the block
// ----------------------------------------------------------------------------
`ifndef SINE_COSINE_MINIMAX_MACROS_SVH
`define SINE_COSINE_MINIMAX_MACROS_SVH

// same-cycle implication
`define SCM_ASSERT_IMP(NAME, CLK, RST_N, A, C) \
  NAME: assert property (@(posedge CLK) disable iff (!RST_N) (A) |-> (C)) \
    else $error("scm check failed");

// implication after a fixed number of cycles
`define SCM_ASSERT_DLY(NAME, CLK, RST_N, A, D, C) \
  NAME: assert property (@(posedge CLK) disable iff (!RST_N) (A) |-> ##D (C)) \
    else $error("scm delayed check failed");

`endif

// File: sv/scm_pkg.sv
// ----------------------------------------------------------------------------
// scm_pkg
// types and fixed-point constants of the sine/cosine pipeline
// ----------------------------------------------------------------------------
package scm_pkg;

  localparam int Q56_W = 64;
  localparam int M1_W = 58;
  localparam int M2_W = 57;
  localparam int X_W = 31;
  localparam int XX_W = 62;
  localparam int X2_W = 32;
  localparam int P_W = 33;
  localparam int MAG_W = 32;
  localparam int MUL_W = 32;
  localparam int PROD_W = 64;
  localparam int WK_FRAC = 30;
  localparam int Q56_TO_Q30 = 26;

  localparam int REDUCE_STEPS = 5;
  localparam int HORNER_STEPS = 6;
  localparam int FOLD_STAGES = 5;
  localparam int SCM_LATENCY = 1 + REDUCE_STEPS + FOLD_STAGES + 2 * HORNER_STEPS + 2;

  localparam logic [Q56_W-1:0] PI_Q56 = 64'h0324_3F6A_8885_A309;
  localparam logic [Q56_W-1:0] TWO_PI_Q56 = PI_Q56 << 1;
  localparam logic [Q56_W-1:0] HALF_PI_Q56 = PI_Q56 >> 1;

  localparam logic [MUL_W-1:0] Q30_ONE = 32'h4000_0000;
  localparam logic [PROD_W-1:0] Q30_HALF = 64'h0000_0000_2000_0000;
  localparam logic [M2_W:0] X_RND = (M2_W+1)'(1) << (Q56_TO_Q30 - 1);

  localparam logic signed [P_W-1:0] SIN_HEAD = P_W'(-26);
  localparam logic signed [P_W-1:0] COS_HEAD = P_W'(-280);

  // addend of each horner step; the last step scales sine by x and passes cosine
  localparam logic signed [P_W-1:0] SIN_ADD_K [HORNER_STEPS] = '{
    P_W'(2956), P_W'(-213040), P_W'(8947846), P_W'(-178956974),
    P_W'(1073741824), P_W'(0)
  };
  localparam logic signed [P_W-1:0] COS_ADD_K [HORNER_STEPS] = '{
    P_W'(26586), P_W'(-1491253), P_W'(44739212), P_W'(-536870912),
    P_W'(1073741824), P_W'(0)
  };

  typedef struct packed {
    logic valid;
    logic sneg;
    logic cflip;
  } scm_ctl_t;

endpackage

// File: sv/sine_cosine_minimax.sv
// ----------------------------------------------------------------------------
// sine_cosine_minimax
// sine and cosine of a fixed-point angle by turn reduction, quadrant fold
// and minimax polynomials in a row of horner cells
// ----------------------------------------------------------------------------
//  channel  ports                                  transfer
//  input    start, busy, in_angle                  start high and busy low
//  result   out_valid, out_sine, out_cosine        out_valid high, one cycle
//
//  one angle per cycle, busy stays low
//  pipeline: input register, five reduction cells, five fold and
//  square stages, six two-stage horner cells, two output stages
//  reset is synchronous and clears every valid flag in the pipeline
//  results cannot be held off by the receiver
// ----------------------------------------------------------------------------
module sine_cosine_minimax
  import scm_pkg::*;
#(
  parameter int ANGLE_WIDTH      = 32,
  parameter int RESULT_FRAC_BITS = 30
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [ANGLE_WIDTH-1:0]      in_angle,
  output logic                               out_valid,
  output logic signed [RESULT_FRAC_BITS+1:0] out_sine,
  output logic signed [RESULT_FRAC_BITS+1:0] out_cosine
);

  localparam int SHL = (RESULT_FRAC_BITS >= WK_FRAC) ? RESULT_FRAC_BITS - WK_FRAC : 0;
  localparam int SHR = (RESULT_FRAC_BITS >= WK_FRAC) ? 0 : WK_FRAC - RESULT_FRAC_BITS;
  localparam int RSH = (SHR > 0) ? SHR - 1 : 0;
  localparam int EXT_W = MAG_W + SHL + 1;
  localparam logic [EXT_W-1:0] RND = (SHR > 0) ? (EXT_W'(1) << RSH) : '0;
  localparam logic [EXT_W-1:0] LIM = EXT_W'(1) << RESULT_FRAC_BITS;

  function automatic logic [RESULT_FRAC_BITS+1:0] to_result(
    input logic [MAG_W-1:0] mag,
    input logic             neg
  );
    logic [EXT_W-1:0]          sc;
    logic [RESULT_FRAC_BITS:0] sat;
    sc  = ((EXT_W'(mag) << SHL) + RND) >> SHR;
    sat = (sc > LIM) ? LIM[RESULT_FRAC_BITS:0] : sc[RESULT_FRAC_BITS:0];
    return neg ? -{1'b0, sat} : {1'b0, sat};
  endfunction

  logic                   accept;
  logic [ANGLE_WIDTH-1:0] amag;

  scm_ctl_t         ctl0_r, ctl0_nxt;
  logic [Q56_W-1:0] u_r, u_nxt;

  scm_ctl_t         red_ctl [REDUCE_STEPS+1];
  logic [Q56_W-1:0] red_r   [REDUCE_STEPS+1];

  scm_ctl_t          ctl_f1_r, ctl_f1_nxt;
  logic [M1_W-1:0]   m1_r, m1_nxt;
  logic [Q56_W-1:0]  m1_full;
  logic              geq;
  scm_ctl_t          ctl_f2_r, ctl_f2_nxt;
  logic [M2_W-1:0]   m2_r, m2_nxt;
  logic [M1_W-1:0]   m2_full;
  logic              flip;
  scm_ctl_t          ctl_f3_r, ctl_f4_r, ctl_f5_r;
  logic [X_W-1:0]    x_f3_r, x_f4_r, x_f5_r, x_nxt;
  logic [M2_W:0]     x_sum;
  logic [XX_W-1:0]   xx_r, xx_nxt;
  logic [XX_W:0]     x2_sum;
  logic [X2_W-1:0]   x2_f5_r, x2_nxt;

  scm_ctl_t              hc_ctl [HORNER_STEPS+1];
  logic [X_W-1:0]        hc_x   [HORNER_STEPS+1];
  logic [X2_W-1:0]       hc_x2  [HORNER_STEPS+1];
  logic signed [P_W-1:0] hc_sin [HORNER_STEPS+1];
  logic signed [P_W-1:0] hc_cos [HORNER_STEPS+1];

  scm_ctl_t              ctl_o1_r;
  logic [MAG_W-1:0]      sin_mag_r, cos_mag_r, sin_mag_nxt, cos_mag_nxt;
  logic                  sin_neg_r, cos_neg_r, sin_neg_nxt, cos_neg_nxt;
  logic signed [P_W-1:0] sin_abs, cos_abs;

  logic                          out_valid_r;
  logic [RESULT_FRAC_BITS+1:0]   out_sine_r, out_cosine_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // input register: magnitude in q.56
  always_comb begin
    amag     = in_angle[ANGLE_WIDTH-1] ? $unsigned(-in_angle) : $unsigned(in_angle);
    u_nxt    = {amag, {(Q56_W-ANGLE_WIDTH){1'b0}}};
    ctl0_nxt = '{valid: accept, sneg: in_angle[ANGLE_WIDTH-1], cflip: 1'b0};
  end

  assign red_ctl[0] = ctl0_r;
  assign red_r[0]   = u_r;

  for (genvar i = 0; i < REDUCE_STEPS; i++) begin : g_reduce
    scm_reduce_cell #(
      .STEP(REDUCE_STEPS - 1 - i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (red_ctl[i]),
      .r_i   (red_r[i]),
      .ctl_o (red_ctl[i+1]),
      .r_o   (red_r[i+1])
    );
  end

  // fold the magnitude into [0, pi/2] with sign flags, round to q.30, square
  always_comb begin
    geq        = red_r[REDUCE_STEPS] >= PI_Q56;
    m1_full    = geq ? TWO_PI_Q56 - red_r[REDUCE_STEPS] : red_r[REDUCE_STEPS];
    m1_nxt     = m1_full[M1_W-1:0];
    ctl_f1_nxt = red_ctl[REDUCE_STEPS];
    ctl_f1_nxt.sneg = red_ctl[REDUCE_STEPS].sneg ^ geq;

    flip       = m1_r > HALF_PI_Q56[M1_W-1:0];
    m2_full    = flip ? PI_Q56[M1_W-1:0] - m1_r : m1_r;
    m2_nxt     = m2_full[M2_W-1:0];
    ctl_f2_nxt = ctl_f1_r;
    ctl_f2_nxt.cflip = flip;

    x_sum  = {1'b0, m2_r} + X_RND;
    x_nxt  = x_sum[Q56_TO_Q30 +: X_W];
    xx_nxt = XX_W'(x_f3_r) * XX_W'(x_f3_r);
    x2_sum = {1'b0, xx_r} + (XX_W+1)'(Q30_HALF);
    x2_nxt = x2_sum[WK_FRAC +: X2_W];
  end

  assign hc_ctl[0] = ctl_f5_r;
  assign hc_x[0]   = x_f5_r;
  assign hc_x2[0]  = x2_f5_r;
  assign hc_sin[0] = SIN_HEAD;
  assign hc_cos[0] = COS_HEAD;

  for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_horner
    scm_horner_cell #(
      .STEP(i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (hc_ctl[i]),
      .x_i   (hc_x[i]),
      .x2_i  (hc_x2[i]),
      .sin_i (hc_sin[i]),
      .cos_i (hc_cos[i]),
      .ctl_o (hc_ctl[i+1]),
      .x_o   (hc_x[i+1]),
      .x2_o  (hc_x2[i+1]),
      .sin_o (hc_sin[i+1]),
      .cos_o (hc_cos[i+1])
    );
  end

  // sign flips from the fold, then magnitude for scaling
  always_comb begin
    sin_abs     = hc_sin[HORNER_STEPS][P_W-1] ? -hc_sin[HORNER_STEPS] : hc_sin[HORNER_STEPS];
    cos_abs     = hc_cos[HORNER_STEPS][P_W-1] ? -hc_cos[HORNER_STEPS] : hc_cos[HORNER_STEPS];
    sin_mag_nxt = sin_abs[MAG_W-1:0];
    cos_mag_nxt = cos_abs[MAG_W-1:0];
    sin_neg_nxt = hc_sin[HORNER_STEPS][P_W-1] ^ hc_ctl[HORNER_STEPS].sneg;
    cos_neg_nxt = hc_cos[HORNER_STEPS][P_W-1] ^ hc_ctl[HORNER_STEPS].cflip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r      <= '0;
      ctl_f1_r    <= '0;
      ctl_f2_r    <= '0;
      ctl_f3_r    <= '0;
      ctl_f4_r    <= '0;
      ctl_f5_r    <= '0;
      ctl_o1_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ctl0_r      <= ctl0_nxt;
      ctl_f1_r    <= ctl_f1_nxt;
      ctl_f2_r    <= ctl_f2_nxt;
      ctl_f3_r    <= ctl_f2_r;
      ctl_f4_r    <= ctl_f3_r;
      ctl_f5_r    <= ctl_f4_r;
      ctl_o1_r    <= hc_ctl[HORNER_STEPS];
      out_valid_r <= ctl_o1_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    u_r          <= u_nxt;
    m1_r         <= m1_nxt;
    m2_r         <= m2_nxt;
    x_f3_r       <= x_nxt;
    x_f4_r       <= x_f3_r;
    xx_r         <= xx_nxt;
    x_f5_r       <= x_f4_r;
    x2_f5_r      <= x2_nxt;
    sin_mag_r    <= sin_mag_nxt;
    cos_mag_r    <= cos_mag_nxt;
    sin_neg_r    <= sin_neg_nxt;
    cos_neg_r    <= cos_neg_nxt;
    out_sine_r   <= to_result(sin_mag_r, sin_neg_r);
    out_cosine_r <= to_result(cos_mag_r, cos_neg_r);
  end

  assign out_valid  = out_valid_r;
  assign out_sine   = $signed(out_sine_r);
  assign out_cosine = $signed(out_cosine_r);

endmodule

// File: sv/scm_reduce_cell.sv
// ----------------------------------------------------------------------------
// scm_reduce_cell
// one restoring step of the turn reduction: subtract 2*pi << STEP if it fits
// ----------------------------------------------------------------------------
module scm_reduce_cell
  import scm_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  scm_ctl_t         ctl_i,
  input  logic [Q56_W-1:0] r_i,
  output scm_ctl_t         ctl_o,
  output logic [Q56_W-1:0] r_o
);

  localparam logic [Q56_W-1:0] DIV = TWO_PI_Q56 << STEP;

  scm_ctl_t         ctl_r;
  logic [Q56_W-1:0] r_r;
  logic [Q56_W-1:0] r_nxt;

  always_comb begin
    r_nxt = (r_i >= DIV) ? r_i - DIV : r_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    r_r <= r_nxt;
  end

  assign ctl_o = ctl_r;
  assign r_o   = r_r;

endmodule

// File: sv/scm_horner_cell.sv
// ----------------------------------------------------------------------------
// scm_horner_cell
// one horner step for both polynomials: multiply, then round and add
// ----------------------------------------------------------------------------
module scm_horner_cell
  import scm_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  scm_ctl_t              ctl_i,
  input  logic [X_W-1:0]        x_i,
  input  logic [X2_W-1:0]       x2_i,
  input  logic signed [P_W-1:0] sin_i,
  input  logic signed [P_W-1:0] cos_i,
  output scm_ctl_t              ctl_o,
  output logic [X_W-1:0]        x_o,
  output logic [X2_W-1:0]       x2_o,
  output logic signed [P_W-1:0] sin_o,
  output logic signed [P_W-1:0] cos_o
);

  localparam bit LAST = (STEP == HORNER_STEPS - 1);
  localparam logic signed [P_W-1:0] SIN_ADD = SIN_ADD_K[STEP];
  localparam logic signed [P_W-1:0] COS_ADD = COS_ADD_K[STEP];

  scm_ctl_t              ctl_a_r, ctl_b_r;
  logic [X_W-1:0]        x_a_r, x_b_r;
  logic [X2_W-1:0]       x2_a_r, x2_b_r;
  logic                  sin_neg_r, cos_neg_r;
  logic [PROD_W-1:0]     sin_prod_r, cos_prod_r;
  logic [PROD_W-1:0]     sin_prod_nxt, cos_prod_nxt;
  logic signed [P_W-1:0] sin_r, cos_r;
  logic signed [P_W-1:0] sin_nxt, cos_nxt;
  logic signed [P_W-1:0] sin_abs, cos_abs;
  logic [MUL_W-1:0]      sin_mul, cos_mul;
  logic [PROD_W-1:0]     sin_rnd, cos_rnd;

  // stage a: magnitude times multiplier
  always_comb begin
    sin_abs = sin_i[P_W-1] ? -sin_i : sin_i;
    cos_abs = cos_i[P_W-1] ? -cos_i : cos_i;
    sin_mul = LAST ? MUL_W'(x_i) : x2_i;
    cos_mul = LAST ? Q30_ONE : x2_i;
    sin_prod_nxt = PROD_W'(sin_abs[MAG_W-1:0]) * PROD_W'(sin_mul);
    cos_prod_nxt = PROD_W'(cos_abs[MAG_W-1:0]) * PROD_W'(cos_mul);
  end

  // stage b: round to q.30, restore sign, add coefficient
  always_comb begin
    sin_rnd = (sin_prod_r + Q30_HALF) >> WK_FRAC;
    cos_rnd = (cos_prod_r + Q30_HALF) >> WK_FRAC;
    sin_nxt = sin_neg_r ? SIN_ADD - $signed(sin_rnd[P_W-1:0])
                        : SIN_ADD + $signed(sin_rnd[P_W-1:0]);
    cos_nxt = cos_neg_r ? COS_ADD - $signed(cos_rnd[P_W-1:0])
                        : COS_ADD + $signed(cos_rnd[P_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
    end else begin
      ctl_a_r <= ctl_i;
      ctl_b_r <= ctl_a_r;
    end
  end

  always_ff @(posedge clk) begin
    x_a_r      <= x_i;
    x2_a_r     <= x2_i;
    sin_neg_r  <= sin_i[P_W-1];
    cos_neg_r  <= cos_i[P_W-1];
    sin_prod_r <= sin_prod_nxt;
    cos_prod_r <= cos_prod_nxt;
    x_b_r      <= x_a_r;
    x2_b_r     <= x2_a_r;
    sin_r      <= sin_nxt;
    cos_r      <= cos_nxt;
  end

  assign ctl_o = ctl_b_r;
  assign x_o   = x_b_r;
  assign x2_o  = x2_b_r;
  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

// File: sv/scm_checker.sv
// ----------------------------------------------------------------------------
// scm_checker
// port-level checks of latency, result range and the zero-angle result, bound to the top level
// ----------------------------------------------------------------------------
`include "sine_cosine_minimax_macros.svh"

module scm_checker
  import scm_pkg::*;
#(
  parameter int ANGLE_WIDTH      = 32,
  parameter int RESULT_FRAC_BITS = 30
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic signed [ANGLE_WIDTH-1:0]      in_angle,
  input logic                               out_valid,
  input logic signed [RESULT_FRAC_BITS+1:0] out_sine,
  input logic signed [RESULT_FRAC_BITS+1:0] out_cosine
);

  localparam logic signed [RESULT_FRAC_BITS+1:0] LIM =
    (RESULT_FRAC_BITS+2)'(1) << RESULT_FRAC_BITS;
  localparam logic signed [RESULT_FRAC_BITS+1:0] NEG_LIM = -LIM;

  logic xfer;
  logic zero_in;
  logic zero_out;
  logic sine_ok;
  logic cosine_ok;

  assign xfer      = start && !busy;
  assign zero_in   = in_angle == '0;
  assign zero_out  = out_sine == '0 && out_cosine == LIM;
  assign sine_ok   = out_sine <= LIM && out_sine >= NEG_LIM;
  assign cosine_ok = out_cosine <= LIM && out_cosine >= NEG_LIM;

  `SCM_ASSERT_DLY(a_result_follows, clk, rst_n, xfer, SCM_LATENCY, out_valid)
  `SCM_ASSERT_IMP(a_result_has_source, clk, rst_n, out_valid, $past(xfer, SCM_LATENCY))
  `SCM_ASSERT_IMP(a_sine_range, clk, rst_n, out_valid, sine_ok)
  `SCM_ASSERT_IMP(a_cosine_range, clk, rst_n, out_valid, cosine_ok)
  `SCM_ASSERT_DLY(a_zero_angle, clk, rst_n, xfer && zero_in, SCM_LATENCY, zero_out)

endmodule

bind sine_cosine_minimax scm_checker #(
  .ANGLE_WIDTH      (ANGLE_WIDTH),
  .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
) u_scm_checker (.*);

// File: verif/sine_cosine_minimax_tb.sv
// ----------------------------------------------------------------------------
// sine_cosine_minimax_tb
// self-checking bench for the sine/cosine pipeline: a table of directed
// angles (zero, the smallest steps, the range ends, multiples of a quarter
// turn and half-turn ties) followed by random angles over the full range,
// near zero and near quarter turns, with random gaps or back-to-back runs.
// every result is checked field by field against a typed row or a bit-exact
// fixed-point model of turn reduction, quadrant fold and minimax polynomials
// ----------------------------------------------------------------------------
module sine_cosine_minimax_tb;

  localparam int PIPE_DEPTH = 25;
  localparam int IDLE_LIMIT = 1000;
  localparam int NUM_RANDOM = 400;
  localparam int NUM_DIRECTED = 23;
  localparam int MAX_REPORTS = 10;

  localparam longint unsigned PI_Q56 = 64'h0324_3F6A_8885_A309;
  localparam longint unsigned TWO_PI_Q56 = PI_Q56 * 2;
  localparam longint unsigned HALF_PI_Q56 = PI_Q56 / 2;
  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint unsigned Q30_RND = 64'd1 << 29;
  localparam int QUARTER_TURN_X10 = 263535893;
  localparam int NEAR_SPAN = 67108864;

  localparam longint SIN_COEF [5] = '{-26, 2956, -213040, 8947846, -178956974};
  localparam longint COS_COEF [5] = '{-280, 26586, -1491253, 44739212, -536870912};

  typedef struct packed {
    logic signed [31:0] sine;
    logic signed [31:0] cosine;
  } trig_pair_t;

  typedef struct packed {
    logic signed [31:0] angle;
    logic               typed;
    logic signed [31:0] sine;
    logic signed [31:0] cosine;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] in_angle = '0;
  logic               out_valid;
  logic signed [31:0] out_sine;
  logic signed [31:0] out_cosine;

  // typed expectation that travels with the angle being offered
  logic               typed_on = 1'b0;
  trig_pair_t         typed_pair = '0;

  trig_pair_t         pending_trig [$];
  int                 mismatch_count = 0;
  int                 idle_cycles = 0;
  bit                 no_gaps = 1'b0;

  sine_cosine_minimax i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_angle  (in_angle),
    .out_valid (out_valid),
    .out_sine  (out_sine),
    .out_cosine(out_cosine)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint mul_q30(input longint a, input longint b);
    longint unsigned ma;
    longint unsigned mb;
    longint unsigned p;
    ma = (a < 0) ? longint'(-a) : a;
    mb = (b < 0) ? longint'(-b) : b;
    p = (ma * mb + Q30_RND) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint minimax_poly(input bit is_cos, input longint x2);
    longint acc;
    acc = is_cos ? COS_COEF[0] : SIN_COEF[0];
    for (int i = 1; i < 5; i++) begin
      acc = mul_q30(acc, x2) + (is_cos ? COS_COEF[i] : SIN_COEF[i]);
    end
    return mul_q30(acc, x2) + Q30_ONE;
  endfunction

  function automatic logic signed [31:0] clamp_unit(input longint v);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : v;
    if (m > 64'd1073741824) begin
      m = 64'd1073741824;
    end
    return (v < 0) ? 32'(-longint'(m)) : 32'(m);
  endfunction

  function automatic trig_pair_t sincos_of(input logic signed [31:0] ang);
    longint unsigned mag;
    longint unsigned turn_rem;
    longint unsigned folded;
    longint          xs;
    longint          x2;
    longint          ps;
    longint          pc;
    bit              sneg;
    bit              cflip;
    trig_pair_t      res;
    sneg = ang[31];
    cflip = 1'b0;
    mag = sneg ? (64'h1_0000_0000 - {32'b0, ang}) : {32'b0, ang};
    turn_rem = (mag << 32) % TWO_PI_Q56;
    folded = turn_rem;
    if (turn_rem >= PI_Q56) begin
      folded = TWO_PI_Q56 - turn_rem;
      sneg = !sneg;
    end
    if (folded > HALF_PI_Q56) begin
      folded = PI_Q56 - folded;
      cflip = 1'b1;
    end
    xs = longint'((folded + (64'd1 << 25)) >> 26);
    x2 = mul_q30(xs, xs);
    ps = mul_q30(minimax_poly(1'b0, x2), xs);
    pc = minimax_poly(1'b1, x2);
    if (sneg) begin
      ps = -ps;
    end
    if (cflip) begin
      pc = -pc;
    end
    res.sine = clamp_unit(ps);
    res.cosine = clamp_unit(pc);
    return res;
  endfunction

  // offer one angle and hold it until the transfer
  task automatic send_angle(input logic signed [31:0] ang, input logic typed,
                            input trig_pair_t pair);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_angle <= ang;
    typed_on <= typed;
    typed_pair <= pair;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  always @(posedge clk) begin
    trig_pair_t want;
    if (rst_n && start && !busy) begin
      pending_trig.push_back(typed_on ? typed_pair : sincos_of(in_angle));
    end
    if (rst_n && out_valid) begin
      if (pending_trig.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected result: sine %0d cosine %0d", out_sine, out_cosine);
        end
      end else begin
        want = pending_trig.pop_front();
        if (out_sine !== want.sine || out_cosine !== want.cosine) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch: sine exp %0d got %0d, cosine exp %0d got %0d",
                     want.sine, out_sine, want.cosine, out_cosine);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || out_valid)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    stim_row_t          dir_rows [NUM_DIRECTED];
    logic signed [31:0] ang;
    longint             near;
    int                 k;
    dir_rows = '{
      '{32'sd0,           1'b1, 32'sd0,   32'sh4000_0000},
      '{32'sd1,           1'b1, 32'sd64,  32'sh4000_0000},
      '{-32'sd1,          1'b1, -32'sd64, 32'sh4000_0000},
      '{32'sh7FFF_FFFF,   1'b0, 32'sd0,   32'sd0},
      '{32'sh8000_0000,   1'b0, 32'sd0,   32'sd0},
      '{32'sd26353589,    1'b0, 32'sd0,   32'sd0},
      '{32'sd26353590,    1'b0, 32'sd0,   32'sd0},
      '{-32'sd26353589,   1'b0, 32'sd0,   32'sd0},
      '{32'sd52707178,    1'b0, 32'sd0,   32'sd0},
      '{32'sd52707179,    1'b0, 32'sd0,   32'sd0},
      '{-32'sd52707178,   1'b0, 32'sd0,   32'sd0},
      '{-32'sd52707179,   1'b0, 32'sd0,   32'sd0},
      '{32'sd105414357,   1'b0, 32'sd0,   32'sd0},
      '{-32'sd105414357,  1'b0, 32'sd0,   32'sd0},
      '{32'sd158121535,   1'b0, 32'sd0,   32'sd0},
      '{32'sd158121536,   1'b0, 32'sd0,   32'sd0},
      '{-32'sd158121536,  1'b0, 32'sd0,   32'sd0},
      '{32'sd13176795,    1'b0, 32'sd0,   32'sd0},
      '{32'sd39530384,    1'b0, 32'sd0,   32'sd0},
      '{32'sd16777216,    1'b0, 32'sd0,   32'sd0},
      '{-32'sd16777216,   1'b0, 32'sd0,   32'sd0},
      '{32'sh4000_0000,   1'b0, 32'sd0,   32'sd0},
      '{32'sh00FF_FFFF,   1'b0, 32'sd0,   32'sd0}
    };
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_angle(dir_rows[i].angle, dir_rows[i].typed,
                 {dir_rows[i].sine, dir_rows[i].cosine});
    end
    for (int i = 0; i < NUM_RANDOM; i++) begin
      no_gaps = ((i / 40) % 3) == 1;
      case ($urandom_range(0, 2))
        0: ang = $urandom;
        1: ang = int'($urandom_range(0, 2 * NEAR_SPAN)) - NEAR_SPAN;
        default: begin
          k = int'($urandom_range(0, 162)) - 81;
          near = (longint'(k) * QUARTER_TURN_X10) / 10
                 + int'($urandom_range(0, 128)) - 64;
          ang = 32'(near);
        end
      endcase
      send_angle(ang, 1'b0, '0);
    end
    start <= 1'b0;
    typed_on <= 1'b0;
    @(posedge clk);
    while (pending_trig.size() != 0) @(posedge clk);
    repeat (2 * PIPE_DEPTH) @(posedge clk);
    if (mismatch_count == 0 && pending_trig.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
